>>> rtl/bmcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmcs_pkg
// Shared types and constants of the bipartite minimum color sum unit.
// ----------------------------------------------------------------------------
package bmcs_pkg;

    localparam int CMD_W     = 2;
    localparam int VERTEX_W  = 7;
    localparam int GUARD_W   = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;

    // Operations that the controller issues to the datapath, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_RD_A,
        OP_WR_A,
        OP_RD_B,
        OP_WR_B,
        OP_SV_INIT,
        OP_ROOT_SKIP,
        OP_ROOT_START,
        OP_POP,
        OP_COMP_END,
        OP_FETCH,
        OP_SCAN,
        OP_REPORT
    } t_dp_op;

    typedef struct packed {
        logic edge_ok;
        logic root_end;
        logic root_visited;
        logic sp_zero;
        logic scan_end;
        logic scan_conflict;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/bmcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmcs_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/bmcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmcs_datapath
// Adjacency rows, walk stack, coloring masks, counters and result register.
// ----------------------------------------------------------------------------
module bmcs_datapath #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bmcs_pkg::t_dp_op               i_op,
    output bmcs_pkg::t_dp_status                o_status,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bmcs_pkg::VERTEX_W-1:0]  i_cfg_wr_data,
    input  wire logic [bmcs_pkg::VERTEX_W-1:0]  i_vertex_a,
    input  wire logic [bmcs_pkg::VERTEX_W-1:0]  i_vertex_b,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_possible,
    output logic [bmcs_pkg::GUARD_W-1:0]        o_guard_count
);
    import bmcs_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [VERTEX_W-1:0] MAX_V7 = VERTEX_W'(MAX_VERTICES);
    localparam logic [CW-1:0]       MAX_C  = CW'(MAX_VERTICES);
    localparam logic [MAX_VERTICES-1:0] BIT0 = MAX_VERTICES'(1);

    logic [VERTEX_W-1:0]     r_vertex_count;
    logic [CW-1:0]           live_n;
    logic [VERTEX_W-1:0]     live_n7;

    logic [MAX_VERTICES-1:0] r_row_valid;
    logic                    r_q_valid;
    logic [VW-1:0]           r_a_idx, r_b_idx;
    logic [MAX_VERTICES-1:0] r_visited, r_color;
    logic [CW-1:0]           r_sp, r_root, r_w;
    logic [CW-1:0]           r_white, r_black;
    logic [GUARD_W-1:0]      r_total;
    logic                    r_fail;
    logic                    r_vcol;
    logic                    r_out_valid, r_possible;
    logic [GUARD_W-1:0]      r_guard;

    logic                    row_we, row_re;
    logic [VW-1:0]           row_waddr, row_raddr;
    logic [MAX_VERTICES-1:0] row_wdata, row_q, row_eff;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr, stk_wdata, stk_q;

    logic [VW-1:0]           w_idx, root_idx;
    logic                    scan_hit, scan_seen, scan_end, root_end;
    logic [CW-1:0]           comp_min;
    logic [VERTEX_W-1:0]     a_m1, b_m1;
    logic                    a_ok, b_ok;

    assign live_n  = (r_vertex_count > MAX_V7) ? MAX_C : r_vertex_count[CW-1:0];
    assign live_n7 = VERTEX_W'(live_n);

    assign a_ok = (i_vertex_a != '0) && (i_vertex_a <= live_n7);
    assign b_ok = (i_vertex_b != '0) && (i_vertex_b <= live_n7);
    assign a_m1 = i_vertex_a - VERTEX_W'(1);
    assign b_m1 = i_vertex_b - VERTEX_W'(1);

    // A row that was never written since the last clear reads as empty.
    assign row_eff  = r_q_valid ? row_q : '0;
    assign w_idx    = r_w[VW-1:0];
    assign root_idx = r_root[VW-1:0];
    assign scan_end = (r_w == live_n);
    assign root_end = (r_root == live_n);
    assign scan_hit  = row_eff[w_idx];
    assign scan_seen = r_visited[w_idx];
    assign comp_min  = (r_white < r_black) ? r_white : r_black;

    always_comb begin
        o_status.edge_ok       = a_ok && b_ok;
        o_status.root_end      = root_end;
        o_status.root_visited  = r_visited[root_idx];
        o_status.sp_zero       = (r_sp == '0);
        o_status.scan_end      = scan_end;
        o_status.scan_conflict = !scan_end && scan_hit && scan_seen
                                 && (r_color[w_idx] == r_vcol);
        o_status.out_free      = !r_out_valid || i_out_ready;
    end

    always_comb begin
        row_we    = 1'b0;
        row_re    = 1'b0;
        row_waddr = r_a_idx;
        row_raddr = r_a_idx;
        row_wdata = row_eff | (BIT0 << r_b_idx);
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = r_sp[VW-1:0];
        stk_wdata = w_idx;
        stk_raddr = VW'(r_sp - CW'(1));
        case (i_op)
            OP_RD_A: begin
                row_re = 1'b1;
            end
            OP_WR_A: begin
                row_we = 1'b1;
            end
            OP_RD_B: begin
                row_re    = 1'b1;
                row_raddr = r_b_idx;
            end
            OP_WR_B: begin
                row_we    = 1'b1;
                row_waddr = r_b_idx;
                row_wdata = row_eff | (BIT0 << r_a_idx);
            end
            OP_FETCH: begin
                row_re    = 1'b1;
                row_raddr = stk_q;
            end
            OP_ROOT_START: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = root_idx;
            end
            OP_POP: begin
                stk_re = 1'b1;
            end
            OP_SCAN: begin
                stk_we = scan_hit && !scan_seen && (r_sp < MAX_C);
            end
            default: begin
            end
        endcase
    end

    bmcs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_q)
    );

    bmcs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_row_valid    <= '0;
            r_q_valid      <= 1'b0;
            r_visited      <= '0;
            r_color        <= '0;
            r_sp           <= '0;
            r_root         <= '0;
            r_w            <= '0;
            r_white        <= '0;
            r_black        <= '0;
            r_total        <= '0;
            r_fail         <= 1'b0;
            r_vcol         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            if (row_re) begin
                r_q_valid <= r_row_valid[row_raddr];
            end
            if (row_we) begin
                r_row_valid[row_waddr] <= 1'b1;
            end
            if (i_op == OP_REPORT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_CLEAR: begin
                    r_row_valid <= '0;
                end
                OP_ACCEPT: begin
                    r_a_idx <= a_m1[VW-1:0];
                    r_b_idx <= b_m1[VW-1:0];
                end
                OP_SV_INIT: begin
                    r_visited <= '0;
                    r_color   <= '0;
                    r_sp      <= '0;
                    r_root    <= '0;
                    r_total   <= '0;
                    r_fail    <= 1'b0;
                end
                OP_ROOT_SKIP: begin
                    r_root <= r_root + CW'(1);
                end
                OP_ROOT_START: begin
                    r_visited[root_idx] <= 1'b1;
                    r_color[root_idx]   <= 1'b1;
                    r_white             <= CW'(1);
                    r_black             <= '0;
                    r_sp                <= CW'(1);
                end
                OP_COMP_END: begin
                    r_total <= r_total + GUARD_W'(comp_min);
                    r_root  <= r_root + CW'(1);
                end
                OP_POP: begin
                    r_sp <= r_sp - CW'(1);
                end
                OP_FETCH: begin
                    r_vcol <= r_color[stk_q];
                    r_w    <= '0;
                end
                OP_SCAN: begin
                    r_w <= r_w + CW'(1);
                    if (scan_hit && scan_seen && (r_color[w_idx] == r_vcol)) begin
                        r_fail <= 1'b1;
                    end
                    if (scan_hit && !scan_seen) begin
                        // A newly reached vertex takes the opposite color.
                        r_visited[w_idx] <= 1'b1;
                        r_color[w_idx]   <= !r_vcol;
                        if (r_vcol) begin
                            r_black <= r_black + CW'(1);
                        end else begin
                            r_white <= r_white + CW'(1);
                        end
                        if (r_sp < MAX_C) begin
                            r_sp <= r_sp + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_REPORT) begin
            r_possible <= !r_fail;
            r_guard    <= r_fail ? '0 : r_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_possible    = r_possible;
    assign o_guard_count = r_guard;

endmodule
`default_nettype wire

>>> rtl/bmcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmcs_ctrl
// Sequencer for edge loads, the component walk and the result hand-off.
// ----------------------------------------------------------------------------
module bmcs_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic [bmcs_pkg::CMD_W-1:0]  i_cmd,
    output logic                             o_req_ready,
    input  wire bmcs_pkg::t_dp_status        i_status,
    output bmcs_pkg::t_dp_op                 o_op
);
    import bmcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_ROOT,
        ST_POP,
        ST_FETCH,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            op = OP_CLEAR;
                        end
                        CMD_ADD: begin
                            op = OP_ACCEPT;
                            if (i_status.edge_ok) begin
                                n_state = ST_RD_A;
                            end
                        end
                        CMD_SOLVE: begin
                            op      = OP_SV_INIT;
                            n_state = ST_ROOT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_A: begin
                op      = OP_RD_A;
                n_state = ST_WR_A;
            end
            ST_WR_A: begin
                op      = OP_WR_A;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                op      = OP_RD_B;
                n_state = ST_WR_B;
            end
            ST_WR_B: begin
                op      = OP_WR_B;
                n_state = ST_IDLE;
            end
            ST_ROOT: begin
                if (i_status.root_end) begin
                    n_state = ST_DONE;
                end else if (i_status.root_visited) begin
                    op = OP_ROOT_SKIP;
                end else begin
                    op      = OP_ROOT_START;
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (i_status.sp_zero) begin
                    op      = OP_COMP_END;
                    n_state = ST_ROOT;
                end else begin
                    op      = OP_POP;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                op      = OP_FETCH;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = ST_POP;
                end else begin
                    op = OP_SCAN;
                    // A same-colored edge ends the whole solve at once.
                    if (i_status.scan_conflict) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    op      = OP_REPORT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_op        = op;

endmodule
`default_nettype wire

>>> rtl/bipartite_min_color_sum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bipartite_min_color_sum_unit
// Loads an undirected graph edge by edge, then two-colors each component and
// reports whether the graph is bipartite and the sum of the smaller classes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         request: cmd, vertex_a, vertex_b
//  m_axis    out        result of a solve: possible, guard_count
//  cfg       in         vertex_count register write
//
//  A clear is handled in the idle state; an edge add runs four row read/write
//  steps on the row memory, which has one read and one write port. The run time
//  of a solve with n vertices is set by the bit-by-bit scan of each popped row.
//  Requests are taken only while the sequencer is idle; a finished result waits
//  in the output register while clears and adds go on. Reset is synchronous and
//  empties the graph at once through per-row valid flags.
// ----------------------------------------------------------------------------
module bipartite_min_color_sum_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [bmcs_pkg::VERTEX_W-1:0]    i_cfg_wr_data,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [1:0] cmd, [8:2] vertex_a, [15:9] vertex_b
    input  wire logic [bmcs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [0] possible, [6:1] guard_count, [7] zero
    output logic [bmcs_pkg::M_TDATA_W-1:0]        o_m_axis_tdata
);
    import bmcs_pkg::*;

    t_dp_op               op;
    t_dp_status           status;
    logic                 possible;
    logic [GUARD_W-1:0]   guard_count;

    bmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_cmd       (i_s_axis_tdata[CMD_W-1:0]),
        .o_req_ready (o_s_axis_tready),
        .i_status    (status),
        .o_op        (op)
    );

    bmcs_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_vertex_a    (i_s_axis_tdata[CMD_W +: VERTEX_W]),
        .i_vertex_b    (i_s_axis_tdata[CMD_W + VERTEX_W +: VERTEX_W]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_possible    (possible),
        .o_guard_count (guard_count)
    );

    assign o_m_axis_tdata = {1'b0, guard_count, possible};

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bipartite minimum color sum unit. Streams clear,
// edge add and solve requests with random gaps on both sides, mirrors the
// graph and its two-coloring in a scoreboard, and checks every solve result.
// ----------------------------------------------------------------------------
module tb_top;
    import bmcs_pkg::*;

    localparam int MAX_VERTICES    = 64;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int MAX_REPORTS     = 10;
    // The limit leaves room for a full 64-vertex solve plus the longest output
    // hold-off several times over.
    localparam int IDLE_LIMIT      = 20000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic               possible;
        logic [GUARD_W-1:0] guard_count;
    } solve_result_t;

    class color_sum_scoreboard;
        logic [63:0]         rows [64];
        logic [VERTEX_W-1:0] vertex_count;
        solve_result_t       expected_solves [$];
        int                  mismatches;
        int                  results_checked;
        int                  requests_noted;

        function new();
            clear_rows();
            vertex_count    = '0;
            mismatches      = 0;
            results_checked = 0;
            requests_noted  = 0;
        endfunction

        function void clear_rows();
            foreach (rows[i]) rows[i] = '0;
        endfunction

        function void set_vertex_count(logic [VERTEX_W-1:0] value);
            vertex_count = value;
        endfunction

        function int live_vertices();
            return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        endfunction

        // Depth-first two-coloring of every component among vertices 0..n-1.
        function solve_result_t two_color_solve();
            solve_result_t      res;
            logic [63:0]        live;
            logic [63:0]        seen;
            logic [63:0]        white;
            logic [63:0]        row;
            logic [GUARD_W-1:0] total;
            int                 pending_vertices [$];
            int                 n;
            int                 u;
            int                 white_n;
            int                 black_n;
            n = live_vertices();
            live = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            seen = '0;
            white = '0;
            total = '0;
            res.possible = 1'b0;
            res.guard_count = '0;
            for (int v = 0; v < n; v++) begin
                if (seen[v]) continue;
                seen[v] = 1'b1;
                white[v] = 1'b1;
                white_n = 1;
                black_n = 0;
                pending_vertices.delete();
                pending_vertices.push_back(v);
                while (pending_vertices.size() > 0) begin
                    u = pending_vertices.pop_back();
                    row = rows[u] & live;
                    for (int w = 0; w < 64; w++) begin
                        if (!row[w]) continue;
                        if (seen[w]) begin
                            if (white[w] == white[u]) return res;
                        end else begin
                            seen[w] = 1'b1;
                            white[w] = ~white[u];
                            if (white[u]) black_n++;
                            else white_n++;
                            pending_vertices.push_back(w);
                        end
                    end
                end
                total = total + GUARD_W'((white_n < black_n) ? white_n : black_n);
            end
            res.possible = 1'b1;
            res.guard_count = total;
            return res;
        endfunction

        function void note_request(logic [S_TDATA_W-1:0] data);
            logic [CMD_W-1:0] cmd;
            int               a;
            int               b;
            int               n;
            cmd = data[CMD_W-1:0];
            a = int'(data[CMD_W +: VERTEX_W]);
            b = int'(data[CMD_W+VERTEX_W +: VERTEX_W]);
            n = live_vertices();
            requests_noted++;
            case (cmd)
                CMD_CLEAR: clear_rows();
                CMD_ADD: begin
                    if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                        rows[a-1][b-1] = 1'b1;
                        rows[b-1][a-1] = 1'b1;
                    end
                end
                CMD_SOLVE: expected_solves.push_back(two_color_solve());
                default: ;
            endcase
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            solve_result_t got;
            solve_result_t want;
            got.possible = data[0];
            got.guard_count = data[1 +: GUARD_W];
            results_checked++;
            if (expected_solves.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with no solve pending: possible=%0b guard_count=%0d",
                             got.possible, got.guard_count);
                return;
            end
            want = expected_solves.pop_front();
            if (got.possible !== want.possible || got.guard_count !== want.guard_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: solve %0d: expected possible=%0b guard_count=%0d, got possible=%0b guard_count=%0d",
                             results_checked, want.possible, want.guard_count,
                             got.possible, got.guard_count);
            end
        endfunction

        function int pending();
            return expected_solves.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [VERTEX_W-1:0]  cfg_wr_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [S_TDATA_W-1:0] req_data = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [M_TDATA_W-1:0] res_data;

    color_sum_scoreboard color_sum_sb;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold_cycles = 0;
    int idle_cycles = 0;
    int useful_requests = 0;
    int settings_written = 0;

    bipartite_min_color_sum_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VERTEX_W-1:0] any_vertex();
        return VERTEX_W'($urandom_range(0, 127));
    endfunction

    // Handshake monitors and the no-progress watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && req_ready) color_sum_sb.note_request(req_data);
            if (res_valid && res_ready) color_sum_sb.check_result(res_data);
            if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int stall;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                res_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                stall = pick_gap(rx_steady);
                if (stall > 0) begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                res_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VERTEX_W-1:0] a,
                                input logic [VERTEX_W-1:0] b);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= {b, a, cmd};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (color_sum_sb.pending() != 0) @(posedge clk);
        // Adds accepted after the last solve may still be in progress.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [VERTEX_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        color_sum_sb.set_vertex_count(value);
        cfg_wr_en <= 1'b0;
        settings_written++;
    endtask

    // Bad endpoints or the unused command; the block must ignore these.
    task automatic send_noise(input int n);
        case ($urandom_range(0, 2))
            0: send_request(CMD_UNUSED, any_vertex(), any_vertex());
            1: send_request(CMD_ADD, any_vertex(), VERTEX_W'($urandom_range(n + 1, 127)));
            default: send_request(CMD_ADD, '0, any_vertex());
        endcase
    endtask

    // One graph: optional clear, random-style edges, a solve, maybe adds and a solve.
    task automatic run_graph_round(input int n);
        logic [63:0] side;
        int          style;
        int          edges;
        int          noise_odds;
        int          a;
        int          b;
        side = {$urandom, $urandom};
        style = $urandom_range(0, 9);
        noise_odds = (style == 9) ? 3 : 12;
        edges = (n == 0) ? $urandom_range(0, 2) : $urandom_range(0, n + n / 2);
        if ($urandom_range(0, 4) != 0) begin
            send_request(CMD_CLEAR, any_vertex(), any_vertex());
            useful_requests++;
        end
        for (int e = 0; e < edges; e++) begin
            if (n == 0 || $urandom_range(0, noise_odds - 1) == 0) begin
                send_noise(n);
                continue;
            end
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
            // Bipartite styles try to keep edges across a random split of the vertices.
            if (style < 6)
                for (int t = 0; t < 8 && side[a-1] == side[b-1]; t++) b = $urandom_range(1, n);
            send_request(CMD_ADD, VERTEX_W'(a), VERTEX_W'(b));
            useful_requests++;
        end
        if (style == 8 && n > 0) begin
            a = $urandom_range(1, n);
            send_request(CMD_ADD, VERTEX_W'(a), VERTEX_W'(a));
            useful_requests++;
        end
        send_request(CMD_SOLVE, any_vertex(), any_vertex());
        useful_requests++;
        if (n > 0 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_request(CMD_ADD, VERTEX_W'($urandom_range(1, n)),
                             VERTEX_W'($urandom_range(1, n)));
                useful_requests++;
            end
            send_request(CMD_SOLVE, any_vertex(), any_vertex());
            useful_requests++;
        end
    endtask

    initial begin
        int  phase;
        int  count;
        int  rounds;
        int  big_phases;
        bit  big;
        color_sum_sb = new();
        phase = 0;
        big_phases = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty graph: solve reports possible with zero, and adds are ignored.
        write_vertex_count(7'd0);
        send_request(CMD_SOLVE, '0, '0);
        send_request(CMD_ADD, 7'd1, 7'd1);
        send_request(CMD_SOLVE, 7'd127, 7'd0);

        // Full size: duplicates, endpoints out of range, unused command, self-loop.
        write_vertex_count(7'd64);
        send_request(CMD_ADD, 7'd1, 7'd2);
        send_request(CMD_ADD, 7'd2, 7'd1);
        send_request(CMD_ADD, 7'd64, 7'd63);
        send_request(CMD_ADD, 7'd0, 7'd5);
        send_request(CMD_ADD, 7'd5, 7'd65);
        send_request(CMD_ADD, 7'd127, 7'd127);
        send_request(CMD_UNUSED, 7'd64, 7'd64);
        send_request(CMD_SOLVE, '0, '0);
        send_request(CMD_ADD, 7'd64, 7'd64);
        send_request(CMD_SOLVE, '0, '0);
        send_request(CMD_CLEAR, 7'd127, 7'd127);
        send_request(CMD_SOLVE, '0, '0);

        // Count above the maximum, an odd cycle, then the count lowered under it.
        write_vertex_count(7'd127);
        send_request(CMD_ADD, 7'd1, 7'd3);
        send_request(CMD_ADD, 7'd3, 7'd5);
        send_request(CMD_ADD, 7'd5, 7'd1);
        send_request(CMD_SOLVE, '0, '0);
        write_vertex_count(7'd4);
        send_request(CMD_SOLVE, '0, '0);

        while (useful_requests < RANDOM_REQUESTS) begin
            big = 1'b0;
            count = $urandom_range(0, 99);
            if (phase == 2) count = $urandom_range(2, 8);
            else if (count < 4) count = 0;
            else if (count < 10 && big_phases < 4) begin
                big = 1'b1;
                big_phases++;
                count = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
            end else if (count < 25) count = $urandom_range(11, 24);
            else count = $urandom_range(1, 10);
            write_vertex_count(VERTEX_W'(count));
            if (count > MAX_VERTICES) count = MAX_VERTICES;

            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            rounds = big ? 1 : $urandom_range(1, 4);
            if (phase == 2) begin
                // Hold the output off while solves keep arriving so the unit backs up.
                tx_steady = 1'b1;
                rounds = 5;
                rx_hold_cycles = HOLD_OFF_CYCLES;
            end
            for (int r = 0; r < rounds; r++) begin
                run_graph_round(count);
                if ($urandom_range(0, 9) == 0) drain_results();
            end
            phase++;
        end

        tx_steady = 1'b0;
        drain_results();
        $display("Checked %0d solve results over %0d requests and %0d vertex count settings,",
                 color_sum_sb.results_checked, color_sum_sb.requests_noted, settings_written);
        $display("including empty, full-size, over-range and lowered counts and a long output stall.");
        if (color_sum_sb.mismatches == 0 && color_sum_sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
